// ===== sv/cqo_pkg.sv =====
// ----------------------------------------------------------------------------
// cqo_pkg
// Shared constants and helpers of the convex quad overlap test: default
// sizes, the coordinate field width, the queue depth and the packing of a
// queued vertex item.
// ----------------------------------------------------------------------------
`default_nettype none

package cqo_pkg;

	localparam int VERTICES_DEF    = 4;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int FIELD_WIDTH     = 16;
	localparam int QUEUE_DEPTH     = 4;

	// item: {last, index, a_x, a_y, b_x, b_y}
	function automatic int item_width(input int vertices, input int coord_width);
		return 4 * coord_width + $clog2(vertices) + 1;
	endfunction

endpackage

`default_nettype wire

// ===== sv/cqo_if.sv =====
// ----------------------------------------------------------------------------
// cqo_if
// Channel interfaces: vertex pairs into the block, overlap flags out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface cqo_vtx_if;
	import cqo_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [FIELD_WIDTH-1:0] a_x;
	logic signed [FIELD_WIDTH-1:0] a_y;
	logic signed [FIELD_WIDTH-1:0] b_x;
	logic signed [FIELD_WIDTH-1:0] b_y;

	modport source (output valid, output a_x, output a_y, output b_x, output b_y,
		input ready);
	modport sink (input valid, input a_x, input a_y, input b_x, input b_y,
		output ready);
endinterface

interface cqo_res_if;
	logic valid;
	logic ready;
	logic overlap;

	modport source (output valid, output overlap, input ready);
	modport sink (input valid, input overlap, output ready);
endinterface

`default_nettype wire

// ===== sv/convex_quad_overlap_test.sv =====
// ----------------------------------------------------------------------------
// convex_quad_overlap_test
// Separating axis overlap test of two convex polygons.
//
// Channel vtx takes one item per vertex index: vertex i of polygon A and
// vertex i of polygon B. After VERTICES items the polygon pair is complete
// and channel res delivers one item: overlap is 1 when no edge normal of
// either polygon separates them (touching counts as overlap).
// A front stage counts and tags the vertices and feeds a four-entry queue;
// the back stores the pair, then runs one projection lane through every
// axis and every vertex, one vertex of each polygon per cycle.
// The single projection lane sets the pace of the pair tests; the queue takes
// the next pair's vertices while a test runs.
// Reset clears the vertex count, the queue and the output register; stored
// vertices are not cleared. A stalled res holds its item, and the block keeps
// taking vertices until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_quad_overlap_test #(
	parameter int VERTICES    = cqo_pkg::VERTICES_DEF,
	parameter int COORD_WIDTH = cqo_pkg::COORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cqo_vtx_if.sink   vtx,
	cqo_res_if.source res
);
	import cqo_pkg::*;

	localparam int IWD = item_width(VERTICES, COORD_WIDTH);

	logic           push_valid, push_ready;
	logic [IWD-1:0] push_item;
	logic           pop_valid, pop_ready;
	logic [IWD-1:0] pop_item;

	cqo_front #(
		.VERTICES    (VERTICES),
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vtx        (vtx),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	cqo_fifo #(
		.WIDTH (IWD),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	cqo_back #(
		.VERTICES    (VERTICES),
		.COORD_WIDTH (COORD_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.res       (res)
	);

endmodule

`default_nettype wire

// ===== sv/cqo_front.sv =====
// ----------------------------------------------------------------------------
// cqo_front
// Accepts vertex pairs, trims the coordinates to the working width, tags each
// item with its vertex index and marks the last vertex of a polygon pair.
// ----------------------------------------------------------------------------
`default_nettype none

module cqo_front #(
	parameter int VERTICES    = cqo_pkg::VERTICES_DEF,
	parameter int COORD_WIDTH = cqo_pkg::COORD_WIDTH_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	cqo_vtx_if.sink                                              vtx,
	output logic                                                 push_valid,
	input  logic                                                 push_ready,
	output logic [cqo_pkg::item_width(VERTICES, COORD_WIDTH)-1:0] push_item
);
	import cqo_pkg::*;

	localparam int IW = $clog2(VERTICES);
	localparam int CW = COORD_WIDTH;

	logic [IW-1:0] cnt_q;
	logic          last;
	logic [CW-1:0] c_ax, c_ay, c_bx, c_by;

	assign last = cnt_q == IW'(VERTICES - 1);

	assign c_ax = CW'($unsigned(vtx.a_x));
	assign c_ay = CW'($unsigned(vtx.a_y));
	assign c_bx = CW'($unsigned(vtx.b_x));
	assign c_by = CW'($unsigned(vtx.b_y));

	assign push_valid = vtx.valid;
	assign vtx.ready  = push_ready;
	assign push_item  = {last, cnt_q, c_ax, c_ay, c_bx, c_by};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (vtx.valid && push_ready) begin
			cnt_q <= last ? '0 : cnt_q + IW'(1);
		end
	end

endmodule

`default_nettype wire

// ===== sv/cqo_fifo.sv =====
// ----------------------------------------------------------------------------
// cqo_fifo
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cqo_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = cqo_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_item,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_item
);
	import cqo_pkg::*;

	localparam int PTRW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wp_q, rp_q;
	logic [CNTW-1:0]  cnt_q;
	logic             push, pop;

	assign push_ready = cnt_q != CNTW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = mem_q[rp_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PTRW'(DEPTH - 1)) ? '0 : wp_q + PTRW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PTRW'(DEPTH - 1)) ? '0 : rp_q + PTRW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_item;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(DEPTH))
		else $error("queue fill count beyond depth");

	a_cnt_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == CNTW'($past(cnt_q) + CNTW'(1)))
		else $error("queue fill count missed a push");

endmodule

`default_nettype wire

// ===== sv/cqo_back.sv =====
// ----------------------------------------------------------------------------
// cqo_back
// Stores both polygons and their edge normals, then steps through every
// axis and vertex with one projection lane, tracks the projection bounds
// and emits the overlap flag through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cqo_back #(
	parameter int VERTICES    = cqo_pkg::VERTICES_DEF,
	parameter int COORD_WIDTH = cqo_pkg::COORD_WIDTH_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 pop_valid,
	output logic                                                 pop_ready,
	input  logic [cqo_pkg::item_width(VERTICES, COORD_WIDTH)-1:0] pop_item,
	cqo_res_if.source                                            res
);
	import cqo_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int IW = $clog2(VERTICES);
	localparam int AW = $clog2(2 * VERTICES);
	localparam int NW = CW + 1;
	localparam int PW = NW + CW;
	localparam int SW = PW + 1;

	typedef enum logic [3:0] {
		S_LOAD  = 4'b0001,
		S_RUN   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	logic signed [CW-1:0] ax_q [VERTICES];
	logic signed [CW-1:0] ay_q [VERTICES];
	logic signed [CW-1:0] bx_q [VERTICES];
	logic signed [CW-1:0] by_q [VERTICES];
	logic signed [NW-1:0] nax_q [VERTICES];
	logic signed [NW-1:0] nay_q [VERTICES];
	logic signed [NW-1:0] nbx_q [VERTICES];
	logic signed [NW-1:0] nby_q [VERTICES];
	logic signed [CW-1:0] pv_ax_q, pv_ay_q, pv_bx_q, pv_by_q;
	logic signed [CW-1:0] fv_ax_q, fv_ay_q, fv_bx_q, fv_by_q;

	logic signed [CW-1:0] u_ax, u_ay, u_bx, u_by;
	logic [IW-1:0]        u_idx;
	logic                 u_last;
	logic                 pop;
	logic signed [NW-1:0] e_anx, e_any, e_bnx, e_bny;
	logic signed [NW-1:0] w_anx, w_any, w_bnx, w_bny;

	logic [AW-1:0]        axis_q;
	logic [IW-1:0]        j_q;
	logic                 issue, is_b, last_j, last_ax;
	logic [IW-1:0]        nidx;
	logic signed [NW-1:0] sel_nx, sel_ny;

	logic                 v_s1, first_s1, lastj_s1, lastax_s1;
	logic signed [NW-1:0] nx_s1, ny_s1;
	logic signed [CW-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic                 v_s2, first_s2, lastj_s2, lastax_s2;
	logic signed [PW-1:0] pax_s2, pay_s2, pbx_s2, pby_s2;
	logic                 v_s3, first_s3, lastj_s3, lastax_s3;
	logic signed [SW-1:0] pa_s3, pb_s3;
	logic signed [SW-1:0] mina_q, maxa_q, minb_q, maxb_q;
	logic                 chk_s4, done_s4;
	logic                 cur_sep, sep_q, ovl_q;
	logic                 res_valid_q, res_ovl_q, res_free;

	// unpack the queued item
	assign u_by   = $signed(pop_item[CW-1:0]);
	assign u_bx   = $signed(pop_item[2*CW-1:CW]);
	assign u_ay   = $signed(pop_item[3*CW-1:2*CW]);
	assign u_ax   = $signed(pop_item[4*CW-1:3*CW]);
	assign u_idx  = pop_item[4*CW+IW-1:4*CW];
	assign u_last = pop_item[4*CW+IW];

	assign pop_ready = state_q == S_LOAD;
	assign pop       = pop_valid && pop_ready;

	// edge normal (-(dy), dx) to the previous vertex and, on the last one, back to the first
	assign e_anx = NW'(pv_ay_q) - NW'(u_ay);
	assign e_any = NW'(u_ax) - NW'(pv_ax_q);
	assign e_bnx = NW'(pv_by_q) - NW'(u_by);
	assign e_bny = NW'(u_bx) - NW'(pv_bx_q);
	assign w_anx = NW'(u_ay) - NW'(fv_ay_q);
	assign w_any = NW'(fv_ax_q) - NW'(u_ax);
	assign w_bnx = NW'(u_by) - NW'(fv_by_q);
	assign w_bny = NW'(fv_bx_q) - NW'(u_bx);

	always_ff @(posedge clk) begin
		if (pop) begin
			ax_q[u_idx] <= u_ax;
			ay_q[u_idx] <= u_ay;
			bx_q[u_idx] <= u_bx;
			by_q[u_idx] <= u_by;
			pv_ax_q     <= u_ax;
			pv_ay_q     <= u_ay;
			pv_bx_q     <= u_bx;
			pv_by_q     <= u_by;
			if (u_idx == '0) begin
				fv_ax_q <= u_ax;
				fv_ay_q <= u_ay;
				fv_bx_q <= u_bx;
				fv_by_q <= u_by;
			end else begin
				nax_q[u_idx - IW'(1)] <= e_anx;
				nay_q[u_idx - IW'(1)] <= e_any;
				nbx_q[u_idx - IW'(1)] <= e_bnx;
				nby_q[u_idx - IW'(1)] <= e_bny;
			end
			if (u_last) begin
				nax_q[VERTICES-1] <= w_anx;
				nay_q[VERTICES-1] <= w_any;
				nbx_q[VERTICES-1] <= w_bnx;
				nby_q[VERTICES-1] <= w_bny;
			end
		end
	end

	// axis and vertex stepping
	assign issue   = state_q == S_RUN;
	assign is_b    = axis_q >= AW'(VERTICES);
	assign nidx    = is_b ? IW'(axis_q - AW'(VERTICES)) : IW'(axis_q);
	assign sel_nx  = is_b ? nbx_q[nidx] : nax_q[nidx];
	assign sel_ny  = is_b ? nby_q[nidx] : nay_q[nidx];
	assign last_j  = j_q == IW'(VERTICES - 1);
	assign last_ax = axis_q == AW'(2 * VERTICES - 1);

	assign cur_sep  = (maxa_q < minb_q) || (maxb_q < mina_q);
	assign res_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			axis_q      <= '0;
			j_q         <= '0;
			v_s1        <= 1'b0;
			first_s1    <= 1'b0;
			lastj_s1    <= 1'b0;
			lastax_s1   <= 1'b0;
			v_s2        <= 1'b0;
			first_s2    <= 1'b0;
			lastj_s2    <= 1'b0;
			lastax_s2   <= 1'b0;
			v_s3        <= 1'b0;
			first_s3    <= 1'b0;
			lastj_s3    <= 1'b0;
			lastax_s3   <= 1'b0;
			chk_s4      <= 1'b0;
			done_s4     <= 1'b0;
			sep_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1      <= issue;
			first_s1  <= issue && j_q == '0;
			lastj_s1  <= issue && last_j;
			lastax_s1 <= issue && last_ax;
			v_s2      <= v_s1;
			first_s2  <= first_s1;
			lastj_s2  <= lastj_s1;
			lastax_s2 <= lastax_s1;
			v_s3      <= v_s2;
			first_s3  <= first_s2;
			lastj_s3  <= lastj_s2;
			lastax_s3 <= lastax_s2;
			chk_s4    <= v_s3 && lastj_s3;
			done_s4   <= v_s3 && lastj_s3 && lastax_s3;

			if (chk_s4 && cur_sep) begin
				sep_q <= 1'b1;
			end

			if (state_q == S_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_LOAD: begin
					if (pop && u_last) begin
						state_q <= S_RUN;
						axis_q  <= '0;
						j_q     <= '0;
						sep_q   <= 1'b0;
					end
				end
				S_RUN: begin
					if (last_j) begin
						j_q <= '0;
						if (last_ax) begin
							state_q <= S_DRAIN;
						end else begin
							axis_q <= axis_q + AW'(1);
						end
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				S_DRAIN: begin
					if (done_s4) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_free) begin
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// projection lane and bound tracking
	always_ff @(posedge clk) begin
		if (issue) begin
			nx_s1 <= sel_nx;
			ny_s1 <= sel_ny;
			ax_s1 <= ax_q[j_q];
			ay_s1 <= ay_q[j_q];
			bx_s1 <= bx_q[j_q];
			by_s1 <= by_q[j_q];
		end
		pax_s2 <= PW'(nx_s1) * PW'(ax_s1);
		pay_s2 <= PW'(ny_s1) * PW'(ay_s1);
		pbx_s2 <= PW'(nx_s1) * PW'(bx_s1);
		pby_s2 <= PW'(ny_s1) * PW'(by_s1);
		pa_s3  <= SW'(pax_s2) + SW'(pay_s2);
		pb_s3  <= SW'(pbx_s2) + SW'(pby_s2);
		if (v_s3) begin
			if (first_s3 || pa_s3 < mina_q) mina_q <= pa_s3;
			if (first_s3 || pa_s3 > maxa_q) maxa_q <= pa_s3;
			if (first_s3 || pb_s3 < minb_q) minb_q <= pb_s3;
			if (first_s3 || pb_s3 > maxb_q) maxb_q <= pb_s3;
		end
		if (state_q == S_DRAIN && done_s4) begin
			ovl_q <= !(sep_q || cur_sep);
		end
		if (state_q == S_DONE && res_free) begin
			res_ovl_q <= ovl_q;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.overlap = res_ovl_q;

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done_s4 |-> state_q == S_DRAIN)
		else $error("last axis finished outside drain");

	a_lane_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(state_q == S_RUN))
		else $error("projection issued outside run");

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised without a finished test");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the convex quad overlap test. Vertex pairs go in as items on
// the vtx channel and a running model of the separating axis test predicts
// one overlap flag for every completed polygon pair. Those flags are matched
// in order against the res channel. Directed pairs cover extreme coordinates,
// touching edges and corners, a one-unit gap and degenerate polygons. Random
// convex quads placed close to each other follow, then raw random vertices.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_top;
	import cqo_pkg::*;

	localparam int NV          = VERTICES_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 2 * NV * NV + 30;
	localparam int COORD_MIN   = -32768;
	localparam int COORD_MAX   = 32767;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	cqo_vtx_if vtx_ch ();
	cqo_res_if res_ch ();

	convex_quad_overlap_test dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx_ch.sink),
		.res    (res_ch.source)
	);

	longint pa_x[NV], pa_y[NV], pb_x[NV], pb_y[NV];
	int     vertex_idx = 0;
	bit     overlap_expected[$];
	bit     idle_on = 1'b1;
	int     mismatches = 0;
	int     ready_hold = 0;
	int     cycle_count = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic bit projections_disjoint(input longint nx, input longint ny);
		longint p, amin, amax, bmin, bmax;
		amin = 0; amax = 0; bmin = 0; bmax = 0;
		for (int j = 0; j < NV; j++) begin
			p = nx * pa_x[j] + ny * pa_y[j];
			if (j == 0 || p < amin) amin = p;
			if (j == 0 || p > amax) amax = p;
			p = nx * pb_x[j] + ny * pb_y[j];
			if (j == 0 || p < bmin) bmin = p;
			if (j == 0 || p > bmax) bmax = p;
		end
		return (amax < bmin) || (bmax < amin);
	endfunction

	function automatic bit poly_has_separating_edge(input bit of_b);
		longint nx, ny;
		int k;
		for (int i = 0; i < NV; i++) begin
			k = (i + 1) % NV;
			if (of_b) begin
				nx = -(pb_y[k] - pb_y[i]);
				ny = pb_x[k] - pb_x[i];
			end else begin
				nx = -(pa_y[k] - pa_y[i]);
				ny = pa_x[k] - pa_x[i];
			end
			if (projections_disjoint(nx, ny))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void record_vertex(input logic signed [FIELD_WIDTH-1:0] ax, ay, bx, by);
		bit ovl;
		pa_x[vertex_idx] = longint'(ax);
		pa_y[vertex_idx] = longint'(ay);
		pb_x[vertex_idx] = longint'(bx);
		pb_y[vertex_idx] = longint'(by);
		if (vertex_idx == NV - 1) begin
			vertex_idx = 0;
			ovl = !poly_has_separating_edge(1'b0) && !poly_has_separating_edge(1'b1);
			overlap_expected = {overlap_expected, ovl};
		end else begin
			vertex_idx++;
		end
	endfunction

	task automatic send_vertex(input logic signed [FIELD_WIDTH-1:0] ax, ay, bx, by);
		int gap;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			vtx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx_ch.valid <= 1'b1;
		vtx_ch.a_x   <= ax;
		vtx_ch.a_y   <= ay;
		vtx_ch.b_x   <= bx;
		vtx_ch.b_y   <= by;
		@(posedge clk);
		while (!vtx_ch.ready) @(posedge clk);
		record_vertex(ax, ay, bx, by);
	endtask

	task automatic send_pair(input int ax[NV], input int ay[NV], input int bx[NV],
		input int by[NV]);
		for (int i = 0; i < NV; i++)
			send_vertex(FIELD_WIDTH'(ax[i]), FIELD_WIDTH'(ay[i]), FIELD_WIDTH'(bx[i]),
				FIELD_WIDTH'(by[i]));
	endtask

	// one vertex on each side of the box gives a convex quad
	function automatic void quad_in_box(input int x0, y0, w, h, output int qx[NV],
		output int qy[NV]);
		int tx[NV], ty[NV];
		int rot, src;
		bit rev;
		tx[0] = x0 + $urandom_range(0, w); ty[0] = y0;
		tx[1] = x0 + w;                    ty[1] = y0 + $urandom_range(0, h);
		tx[2] = x0 + $urandom_range(0, w); ty[2] = y0 + h;
		tx[3] = x0;                        ty[3] = y0 + $urandom_range(0, h);
		rot = $urandom_range(0, NV - 1);
		rev = $urandom_range(0, 1);
		for (int i = 0; i < NV; i++) begin
			src = rev ? (rot + NV - i) % NV : (rot + i) % NV;
			qx[i] = tx[src];
			qy[i] = ty[src];
		end
	endfunction

	function automatic int clamp_origin(input int v, input int w);
		if (v < COORD_MIN)
			return COORD_MIN;
		if (v > COORD_MAX - w)
			return COORD_MAX - w;
		return v;
	endfunction

	function automatic int pick_span();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $urandom_range(0, 16);
		if (r < 9)
			return $urandom_range(0, 2048);
		return $urandom_range(0, 65535);
	endfunction

	task automatic test_extreme_coords();
		send_pair('{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN},
			'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX},
			'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX},
			'{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN});
		send_pair('{COORD_MIN, COORD_MIN + 1, COORD_MIN + 1, COORD_MIN},
			'{COORD_MIN, COORD_MIN, COORD_MIN + 1, COORD_MIN + 1},
			'{COORD_MAX - 1, COORD_MAX, COORD_MAX, COORD_MAX - 1},
			'{COORD_MAX - 1, COORD_MAX - 1, COORD_MAX, COORD_MAX});
	endtask

	task automatic test_touching();
		send_pair('{0, 10, 10, 0}, '{0, 0, 10, 10}, '{10, 20, 20, 10}, '{0, 0, 10, 10});
		send_pair('{0, 10, 10, 0}, '{0, 0, 10, 10}, '{10, 20, 20, 10}, '{10, 10, 20, 20});
	endtask

	task automatic test_separated_gap();
		send_pair('{0, 10, 10, 0}, '{0, 0, 10, 10}, '{11, 21, 21, 11}, '{0, 0, 10, 10});
	endtask

	// point polygon against a collinear polygon with a repeated vertex
	task automatic test_degenerate();
		send_pair('{5, 5, 5, 5}, '{5, 5, 5, 5}, '{0, 4, 8, 4}, '{0, 4, 8, 4});
	endtask

	task automatic test_random_quads(input int pairs);
		int ax[NV], ay[NV], bx[NV], by[NV];
		int wa, ha, wb, hb, ax0, ay0, bx0, by0;
		for (int n = 0; n < pairs; n++) begin
			if (n % 40 == 0)
				idle_on = $urandom_range(0, 3) != 0;
			wa = pick_span(); ha = pick_span();
			wb = pick_span(); hb = pick_span();
			ax0 = COORD_MIN + $urandom_range(0, 65535 - wa);
			ay0 = COORD_MIN + $urandom_range(0, 65535 - ha);
			bx0 = clamp_origin(ax0 + $urandom_range(0, wa + wb + 4) - wb - 2, wb);
			by0 = clamp_origin(ay0 + $urandom_range(0, ha + hb + 4) - hb - 2, hb);
			quad_in_box(ax0, ay0, wa, ha, ax, ay);
			quad_in_box(bx0, by0, wb, hb, bx, by);
			if ($urandom_range(0, 1))
				send_pair(ax, ay, bx, by);
			else
				send_pair(bx, by, ax, ay);
		end
	endtask

	task automatic test_random_vertices(input int pairs);
		idle_on = 1'b1;
		for (int n = 0; n < pairs * NV; n++)
			send_vertex(FIELD_WIDTH'($urandom), FIELD_WIDTH'($urandom),
				FIELD_WIDTH'($urandom), FIELD_WIDTH'($urandom));
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("convex_quad_overlap_test: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		bit want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (overlap_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: overlap %0b", res_ch.overlap);
			end else begin
				want = overlap_expected.pop_front();
				if (res_ch.overlap !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("overlap wrong: expected %0b actual %0b", want,
							res_ch.overlap);
				end
			end
		end
		if (!idle_on) begin
			res_ch.ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold--;
			res_ch.ready <= 1'b0;
		end else begin
			ready_hold = pick_gap();
			res_ch.ready <= ready_hold == 0;
		end
	end

	initial begin
		vtx_ch.valid <= 1'b0;
		vtx_ch.a_x   <= '0;
		vtx_ch.a_y   <= '0;
		vtx_ch.b_x   <= '0;
		vtx_ch.b_y   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extreme_coords();
		test_touching();
		test_separated_gap();
		test_degenerate();
		test_random_quads(300);
		test_random_vertices(50);
		vtx_ch.valid <= 1'b0;

		// drain
		while (overlap_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("convex_quad_overlap_test: match");
		else
			$display("convex_quad_overlap_test: mismatch");
		$finish;
	end

endmodule
